// ===== hdl/gray_histogram_normalized_defines.svh =====
// Assertion macros for the gray histogram block.
// Included by the top level; no other dependencies.
`ifndef GRAY_HISTOGRAM_NORMALIZED_DEFINES_SVH
`define GRAY_HISTOGRAM_NORMALIZED_DEFINES_SVH

`ifndef SYNTHESIS
// Check with reset masking.
`define GHN_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also holds during reset.
`define GHN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GHN_ASSERT(lbl, clk, rst, prop, msg)
`define GHN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/ghn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the gray histogram block.
// No dependencies.
package ghn_pkg;

  localparam int HEIGHT_W   = 12;
  localparam int FIELD_W    = 8;
  localparam int OUT_CNT_W  = 24;

  localparam logic [HEIGHT_W-1:0] BAR_HEIGHT_RESET = 12'd400;

  typedef enum logic [1:0] {
    CMD_COUNT = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== hdl/ghn_bin_ram.sv =====
`timescale 1ns / 1ps
// Bin count store: one write port, one read port, registered read data.
// No package dependencies.
module ghn_bin_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ghn_divider.sv =====
`timescale 1ns / 1ps
// Restoring divider for the bar height, one quotient bit per cycle.
// Depends on ghn_pkg. The quotient is known to fit in HEIGHT_W bits.
module ghn_divider #(
  parameter int DEN_W = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               take,
  input  logic [DEN_W+ghn_pkg::HEIGHT_W-1:0] num,
  input  logic [DEN_W-1:0]                   den,
  output ghn_pkg::div_status_t               status,
  output logic [ghn_pkg::HEIGHT_W-1:0]       quotient
);

  localparam int HW     = ghn_pkg::HEIGHT_W;
  localparam int NW     = DEN_W + HW;
  localparam int STEP_W = $clog2(HW);

  logic [NW-1:0]     rem;
  logic [NW-1:0]     dsh;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic              fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      rem      <= num;
      dsh      <= NW'(den) << (HW - 1);
      step     <= '0;
      quotient <= '0;
      // zero peak gives zero height
      busy     <= (den != '0);
      done     <= (den == '0);
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[HW-2:0], fits};
      dsh      <= dsh >> 1;
      step     <= step + 1'b1;
      if (step == STEP_W'(HW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else if (take) begin
      done <= 1'b0;
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== hdl/gray_histogram_normalized.sv =====
`timescale 1ns / 1ps
// Gray histogram top level: command stream in, bin read results out.
// Depends on ghn_pkg, ghn_bin_ram, ghn_divider and the assertion macro header.
//
// Usage:
//   Slave stream s_axis carries commands: count a pixel, read a bin, clear.
//   Master stream m_axis carries one result per read command.
//   cfg_we/cfg_wdata write the full-scale bar height (reset 400).
// Throughput: pixel counts go at one transaction per cycle; a back-to-back
//   pixel to the same bin is forwarded from the last write, so there is no
//   bubble. Reads and clears block the input until they finish.
// Read path: a read result goes through the memory read, the stage 2 operand
//   register (the multiply is combinational), the single bit-serial divider
//   and the output register; a zero peak skips the divider steps.
// Clear: zeroes the store one bin per cycle, every bin, input held off.
// Reset: the same clearing pass runs after rst drops; s_axis_tready stays
//   low until it ends. Peak resets to zero.
// Stall: a result waits in the output register while m_axis_tready is low;
//   pixels are still taken, a further read waits in the divider.
`include "gray_histogram_normalized_defines.svh"
module gray_histogram_normalized #(
  parameter int BIN_COUNT  = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // command[1:0], pixel_value[9:2], bin_index[17:10]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // read_index[7:0], bin_count[31:8],
                                     // peak_count[55:32], scaled_height[67:56]
);

  localparam int HW     = ghn_pkg::HEIGHT_W;
  localparam int FW     = ghn_pkg::FIELD_W;
  localparam int OCW    = ghn_pkg::OUT_CNT_W;
  localparam int CW     = COUNT_BITS;
  localparam int ADDR_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int IDX_W  = (ADDR_W > FW) ? ADDR_W : FW;
  localparam logic [IDX_W:0]  BIN_LIM   = (IDX_W + 1)'(BIN_COUNT);
  localparam logic [CW-1:0]   COUNT_MAX = '1;
  localparam logic [ADDR_W-1:0] LAST_BIN = ADDR_W'(BIN_COUNT - 1);

  // input decode
  ghn_pkg::cmd_t     in_cmd;
  logic [FW-1:0]     in_pix;
  logic [FW-1:0]     in_bin;
  logic [FW-1:0]     sel_idx;
  logic [IDX_W-1:0]  sel_ext;
  logic              sel_inr;
  logic              in_fire;

  assign in_cmd  = ghn_pkg::cmd_t'(s_axis_tdata[1:0]);
  assign in_pix  = s_axis_tdata[9:2];
  assign in_bin  = s_axis_tdata[17:10];
  assign sel_idx = (in_cmd == ghn_pkg::CMD_READ) ? in_bin : in_pix;
  assign sel_ext = IDX_W'(sel_idx);
  assign sel_inr = {1'b0, sel_ext} < BIN_LIM;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // configuration
  logic [HW-1:0] bar;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar <= ghn_pkg::BAR_HEIGHT_RESET;
    end else if (cfg_we) begin
      bar <= cfg_wdata;
    end
  end

  // stage 1: memory data back
  logic              s1_valid;
  ghn_pkg::cmd_t     s1_cmd;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_inr;
  logic [FW-1:0]     s1_idx;

  // last write, for forwarding into a read that crossed it
  logic              lw_valid;
  logic [ADDR_W-1:0] lw_addr;
  logic [CW-1:0]     lw_data;

  // clearing pass
  logic              clr_busy;
  logic [ADDR_W-1:0] clr_addr;

  logic [CW-1:0]     peak;
  logic [CW-1:0]     ram_q;
  logic [CW-1:0]     old_cnt;
  logic [CW-1:0]     new_cnt;
  logic              pix_wr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CW-1:0]     ram_wdata;

  assign old_cnt   = (lw_valid && lw_addr == s1_addr) ? lw_data : ram_q;
  assign new_cnt   = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
  assign pix_wr    = s1_valid && s1_cmd == ghn_pkg::CMD_COUNT && s1_inr;
  assign ram_we    = clr_busy || pix_wr;
  assign ram_waddr = clr_busy ? clr_addr : s1_addr;
  assign ram_wdata = clr_busy ? '0 : new_cnt;

  ghn_bin_ram #(
    .DEPTH  (BIN_COUNT),
    .ADDR_W (ADDR_W),
    .DATA_W (CW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (sel_ext[ADDR_W-1:0]),
    .rdata (ram_q)
  );

  // stage 2: read operands for the divider
  logic          s2_valid;
  logic [CW-1:0] s2_cnt;
  logic [CW-1:0] s2_peak;
  logic [FW-1:0] s2_idx;
  logic [CW+HW-1:0] prod;

  assign prod = (CW + HW)'(s2_cnt) * (CW + HW)'(bar);

  ghn_pkg::div_status_t div_st;
  logic [HW-1:0]        div_q;
  logic                 div_take;

  ghn_divider #(
    .DEN_W (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (s2_valid),
    .take     (div_take),
    .num      (prod),
    .den      (s2_peak),
    .status   (div_st),
    .quotient (div_q)
  );

  // output register
  logic           out_valid;
  logic [FW-1:0]  out_idx;
  logic [OCW-1:0] out_cnt;
  logic [OCW-1:0] out_peak;
  logic [HW-1:0]  out_h;

  assign div_take = div_st.done && (!out_valid || m_axis_tready);

  assign s_axis_tready = !clr_busy && !(s1_valid && s1_cmd != ghn_pkg::CMD_COUNT)
                         && !s2_valid && !div_st.busy && !div_st.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      lw_valid <= 1'b0;
      clr_busy <= 1'b1;
      clr_addr <= '0;
      peak     <= '0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
      s2_valid <= 1'b0;
      if (ram_we) begin
        lw_valid <= 1'b1;
        lw_addr  <= ram_waddr;
        lw_data  <= ram_wdata;
      end
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST_BIN) begin
          clr_busy <= 1'b0;
        end
      end
      if (s1_valid) begin
        case (s1_cmd)
          ghn_pkg::CMD_COUNT: begin
            if (s1_inr && new_cnt > peak) begin
              peak <= new_cnt;
            end
          end
          ghn_pkg::CMD_READ: begin
            s2_valid <= 1'b1;
          end
          ghn_pkg::CMD_CLEAR: begin
            clr_busy <= 1'b1;
            clr_addr <= '0;
            peak     <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd  <= in_cmd;
      s1_addr <= sel_ext[ADDR_W-1:0];
      s1_inr  <= sel_inr;
      s1_idx  <= in_bin;
    end
    if (s1_valid && s1_cmd == ghn_pkg::CMD_READ) begin
      s2_cnt  <= s1_inr ? old_cnt : '0;
      s2_peak <= peak;
      s2_idx  <= s1_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_take) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      out_idx  <= s2_idx;
      out_cnt  <= OCW'(s2_cnt);
      out_peak <= OCW'(s2_peak);
      out_h    <= div_q;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_h, out_peak, out_cnt, out_idx};

  // checks
  `GHN_ASSERT(a_no_take_in_clear, clk, rst, clr_busy |-> !s_axis_tready, "input taken during clear")
  `GHN_ASSERT(a_peak_covers_write, clk, rst, pix_wr |=> peak >= $past(new_cnt), "peak below a bin count")
  `GHN_ASSERT(a_div_start_idle, clk, rst, s2_valid |-> !div_st.busy && !div_st.done, "divider restarted while in use")
  `GHN_ASSERT(a_height_needs_peak, clk, rst, out_valid && out_h != '0 |-> out_peak != '0, "nonzero height with zero peak")

endmodule

// ===== dv/tb_gray_histogram_normalized.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gray_histogram_normalized: command stream in, bin reads out.
// Depends on ghn_pkg and the RTL top level; the bin store and bar height are modeled here.
module tb_gray_histogram_normalized;

  localparam int HEIGHT_W      = ghn_pkg::HEIGHT_W;
  localparam int OUT_CNT_W     = ghn_pkg::OUT_CNT_W;
  localparam int FIELD_W       = ghn_pkg::FIELD_W;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_BINS      = 256;
  localparam int READ_LATENCY  = 20;    // a margin over the read path
  localparam int WATCHDOG_MAX  = 2000;  // covers clear pass, stalls and sender gaps
  localparam int PHASE_ITEMS   = 300;
  localparam int NUM_PHASES    = 6;

  typedef struct packed {
    logic [HEIGHT_W-1:0]  height;
    logic [OUT_CNT_W-1:0] peak;
    logic [OUT_CNT_W-1:0] count;
    logic [FIELD_W-1:0]   index;
  } read_result_t;

  typedef struct {
    logic [1:0]   cmd;
    logic [7:0]   pix;
    logic [7:0]   idx;
    bit           typed;
    read_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [11:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // command[1:0], pixel_value[9:2], bin_index[17:10]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // read_index[7:0], bin_count[31:8],
                               // peak_count[55:32], scaled_height[67:56]

  gray_histogram_normalized u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // histogram model
  logic [OUT_CNT_W-1:0] hist_bins [NUM_BINS];
  logic [OUT_CNT_W-1:0] hist_peak;
  logic [HEIGHT_W-1:0]  bar_h;

  read_result_t pending_reads[$];
  stim_row_t    directed_rows[$];
  int           mismatches;
  int           burst_left;
  int           idle_cycles;
  int           stall_left;
  int           stall_mode;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Update the histogram model with one command; returns 1 when a read result is due.
  function automatic bit histogram_apply(input logic [1:0] cmd, input logic [7:0] pix,
                                         input logic [7:0] idx, output read_result_t res);
    logic [OUT_CNT_W-1:0]         cnt;
    logic [OUT_CNT_W+HEIGHT_W-1:0] prod;
    res = '0;
    if (cmd == ghn_pkg::CMD_COUNT) begin
      cnt = hist_bins[pix];
      if (cnt != {OUT_CNT_W{1'b1}}) cnt = cnt + 1'b1;
      hist_bins[pix] = cnt;
      if (cnt > hist_peak) hist_peak = cnt;
      return 1'b0;
    end else if (cmd == ghn_pkg::CMD_READ) begin
      cnt  = hist_bins[idx];
      prod = (OUT_CNT_W + HEIGHT_W)'(cnt) * (OUT_CNT_W + HEIGHT_W)'(bar_h);
      res.index  = idx;
      res.count  = cnt;
      res.peak   = hist_peak;
      res.height = (hist_peak == '0) ? '0 : HEIGHT_W'(prod / hist_peak);
      return 1'b1;
    end else if (cmd == ghn_pkg::CMD_CLEAR) begin
      foreach (hist_bins[i]) hist_bins[i] = '0;
      hist_peak = '0;
    end
    return 1'b0;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [7:0] pix, input logic [7:0] idx,
                         input bit typed, input logic [7:0] e_idx, input int e_cnt,
                         input int e_peak, input int e_height);
    stim_row_t row;
    row.cmd        = cmd;
    row.pix        = pix;
    row.idx        = idx;
    row.typed      = typed;
    row.res.index  = e_idx;
    row.res.count  = OUT_CNT_W'(e_cnt);
    row.res.peak   = OUT_CNT_W'(e_peak);
    row.res.height = HEIGHT_W'(e_height);
    directed_rows.push_back(row);
  endtask

  // Present one command, wait for the transaction, then model it and pace the sender.
  task automatic send_command(input logic [1:0] cmd, input logic [7:0] pix,
                              input logic [7:0] idx, input bit typed,
                              input read_result_t typed_res, input bit last);
    read_result_t res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, idx, pix, cmd};
    do @(posedge clk); while (!s_axis_tready);
    if (histogram_apply(cmd, pix, idx, res))
      pending_reads.push_back(typed ? typed_res : res);
    if (last || burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      if (!last) repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_bar_height(input logic [11:0] value);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (READ_LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    bar_h = value;
  endtask

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    read_result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reads.size() == 0) begin
        $error("read result with none outstanding: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        exp_r = pending_reads.pop_front();
        check_field("read_index", 32'(exp_r.index), 32'(m_axis_tdata[7:0]));
        check_field("bin_count", 32'(exp_r.count), 32'(m_axis_tdata[31:8]));
        check_field("peak_count", 32'(exp_r.peak), 32'(m_axis_tdata[55:32]));
        check_field("scaled_height", 32'(exp_r.height), 32'(m_axis_tdata[67:56]));
      end
    end
  end

  // receiver backpressure: a stall mode is picked at random whenever the stall counter runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_axis_tready <= 1'b0;
      end
    endcase
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [1:0]   cmd;
    logic [7:0]   pix;
    logic [7:0]   idx;
    logic [7:0]   hot_base;
    logic [11:0]  phase_heights [NUM_PHASES];
    int           sel;
    int           counted;
    read_result_t no_res;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    stall_left    = 0;
    stall_mode    = 0;
    idle_cycles   = 0;
    mismatches    = 0;
    burst_left    = 0;
    no_res        = '0;
    foreach (hist_bins[i]) hist_bins[i] = '0;
    hist_peak = '0;
    bar_h     = ghn_pkg::BAR_HEIGHT_RESET;

    // directed table, bar height at its reset value
    add_row(ghn_pkg::CMD_READ,  8'h00, 8'h00, 1, 8'h00, 0, 0, 0);  // empty store, zero peak
    add_row(ghn_pkg::CMD_READ,  8'hff, 8'hff, 1, 8'hff, 0, 0, 0);
    add_row(ghn_pkg::CMD_COUNT, 8'h00, 8'hff, 0, 0, 0, 0, 0);
    add_row(ghn_pkg::CMD_COUNT, 8'hff, 8'h00, 0, 0, 0, 0, 0);
    add_row(ghn_pkg::CMD_COUNT, 8'hff, 8'h5a, 0, 0, 0, 0, 0);      // same bin back to back
    add_row(ghn_pkg::CMD_READ,  8'h00, 8'hff, 1, 8'hff, 2, 2, 400);
    add_row(ghn_pkg::CMD_READ,  8'hff, 8'h00, 1, 8'h00, 1, 2, 200);
    add_row(ghn_pkg::CMD_READ,  8'h33, 8'h80, 1, 8'h80, 0, 2, 0);
    add_row(CMD_UNUSED,         8'hff, 8'hff, 0, 0, 0, 0, 0);      // ignored command
    add_row(ghn_pkg::CMD_READ,  8'h00, 8'hff, 1, 8'hff, 2, 2, 400);
    add_row(ghn_pkg::CMD_COUNT, 8'haa, 8'h55, 0, 0, 0, 0, 0);
    add_row(ghn_pkg::CMD_COUNT, 8'h55, 8'haa, 0, 0, 0, 0, 0);
    add_row(ghn_pkg::CMD_READ,  8'h55, 8'haa, 1, 8'haa, 1, 2, 200);
    add_row(ghn_pkg::CMD_CLEAR, 8'hff, 8'hff, 0, 0, 0, 0, 0);
    add_row(ghn_pkg::CMD_READ,  8'haa, 8'hff, 1, 8'hff, 0, 0, 0);
    add_row(ghn_pkg::CMD_COUNT, 8'h07, 8'h00, 0, 0, 0, 0, 0);
    add_row(ghn_pkg::CMD_COUNT, 8'h07, 8'h00, 0, 0, 0, 0, 0);
    add_row(ghn_pkg::CMD_COUNT, 8'h07, 8'h00, 0, 0, 0, 0, 0);
    add_row(ghn_pkg::CMD_COUNT, 8'h09, 8'h00, 0, 0, 0, 0, 0);
    add_row(ghn_pkg::CMD_READ,  8'h00, 8'h07, 1, 8'h07, 3, 3, 400);
    add_row(ghn_pkg::CMD_READ,  8'h00, 8'h09, 0, 0, 0, 0, 0);      // 400/3, from the predictor

    phase_heights[0] = 12'd4095;
    phase_heights[1] = 12'd1;
    phase_heights[2] = 12'd0;                                 // height always zero
    phase_heights[3] = 12'($urandom_range(1, 4095));
    phase_heights[4] = 12'($urandom_range(1, 4095));
    phase_heights[5] = ghn_pkg::BAR_HEIGHT_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].pix, directed_rows[i].idx,
                   directed_rows[i].typed, directed_rows[i].res,
                   i == directed_rows.size() - 1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_bar_height(phase_heights[ph]);
      hot_base = 8'($urandom_range(0, 255));
      counted  = 0;
      while (counted < PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        pix = ($urandom_range(0, 9) < 6) ? hot_base + 8'($urandom_range(0, 3))
                                         : 8'($urandom_range(0, 255));
        idx = ($urandom_range(0, 1) == 0) ? hot_base + 8'($urandom_range(0, 5))
                                          : 8'($urandom_range(0, 255));
        if (sel < 1)       cmd = ghn_pkg::CMD_CLEAR;
        else if (sel < 3)  cmd = CMD_UNUSED;
        else if (sel < 18) cmd = ghn_pkg::CMD_READ;
        else               cmd = ghn_pkg::CMD_COUNT;
        if (cmd != CMD_UNUSED) counted++;
        send_command(cmd, pix, idx, 0, no_res, counted == PHASE_ITEMS);
      end
    end

    while (pending_reads.size() != 0) @(posedge clk);
    repeat (READ_LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ghn_pkg.sv
hdl/ghn_bin_ram.sv
hdl/ghn_divider.sv
hdl/gray_histogram_normalized.sv
dv/tb_gray_histogram_normalized.sv
